@@ src/sync_frame_parser_checksum_unit_assert.svh @@
// Assertion macros for the frame parser; clocked on clk_i, disabled in reset.
`ifndef SYNC_FRAME_PARSER_CHECKSUM_UNIT_ASSERT_SVH
`define SYNC_FRAME_PARSER_CHECKSUM_UNIT_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define SFPC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SFPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ src/sfpc_pkg.sv @@
// Shared constants, register indexes and controller/datapath structs for the frame parser.
package sfpc_pkg;

  localparam int MaxPayload = 64;
  localparam int IdxW       = $clog2(MaxPayload);
  localparam int LenW       = $clog2(MaxPayload + 1);
  localparam int ByteW      = 8;
  localparam int CfgIdxW    = 3;
  localparam int OutDataW   = 40;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_ONE     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_KEY_TWO     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_KEY_THREE   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_KEY_FOUR    = 3'd6;

  localparam logic [ByteW-1:0] ChecksumBase = 8'd255;

  typedef struct packed {
    logic ld_addr_hi;
    logic ld_addr_lo;
    logic ld_key;
    logic ld_len;
    logic wr_byte;
    logic start_emit;
    logic rd_byte;
    logic inc_idx;
  } cmd_t;

  typedef struct packed {
    logic sync_first_hit;
    logic sync_second_hit;
    logic key_hit;
    logic len_zero;
    logic len_over;
    logic data_done;
    logic sum_match;
    logic frame_empty;
    logic out_last;
  } sts_t;

endpackage

@@ src/sfpc_datapath.sv @@
// Datapath: configuration registers, header holds, running checksum, payload store, result fields.
module sfpc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sfpc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [sfpc_pkg::ByteW-1:0]          cfg_data_i,
  input  logic [sfpc_pkg::ByteW-1:0]          rx_byte_i,
  input  sfpc_pkg::cmd_t                      cmd_i,
  output sfpc_pkg::sts_t                      sts_o,
  output logic [15:0]                         sender_address_o,
  output logic [sfpc_pkg::ByteW-1:0]          frame_key_o,
  output logic [sfpc_pkg::ByteW-1:0]          payload_byte_o,
  output logic [sfpc_pkg::IdxW-1:0]           byte_index_o,
  output logic                                has_payload_o
);

  logic [sfpc_pkg::ByteW-1:0] sync_first_q, sync_second_q;
  logic [sfpc_pkg::LenW-1:0]  max_payload_q;
  logic [sfpc_pkg::ByteW-1:0] key_one_q, key_two_q, key_three_q, key_four_q;

  logic [15:0]                addr_q;
  logic [sfpc_pkg::ByteW-1:0] key_q;
  logic [sfpc_pkg::LenW-1:0]  len_q;
  logic [sfpc_pkg::LenW-1:0]  count_q;
  logic [sfpc_pkg::ByteW-1:0] sum_q, sum_d;
  logic [sfpc_pkg::IdxW-1:0]  idx_q;
  logic                       empty_q;
  logic [sfpc_pkg::ByteW-1:0] rd_q;
  logic [sfpc_pkg::ByteW-1:0] store_q [sfpc_pkg::MaxPayload];

  logic [sfpc_pkg::LenW-1:0]  limit;
  logic [sfpc_pkg::ByteW:0]   sum_wide;
  logic [sfpc_pkg::LenW-1:0]  count_inc;
  logic [sfpc_pkg::LenW-1:0]  idx_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= '0;
      sync_second_q <= '0;
      max_payload_q <= sfpc_pkg::LenW'(sfpc_pkg::MaxPayload);
      key_one_q     <= 8'd0;
      key_two_q     <= 8'd1;
      key_three_q   <= 8'd2;
      key_four_q    <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sfpc_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        sfpc_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        sfpc_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg_data_i[sfpc_pkg::LenW-1:0];
        sfpc_pkg::CFG_KEY_ONE:     key_one_q     <= cfg_data_i;
        sfpc_pkg::CFG_KEY_TWO:     key_two_q     <= cfg_data_i;
        sfpc_pkg::CFG_KEY_THREE:   key_three_q   <= cfg_data_i;
        sfpc_pkg::CFG_KEY_FOUR:    key_four_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Running sum kept reduced modulo 255.
  always_comb begin
    sum_wide = {1'b0, sum_q} + {1'b0, rx_byte_i};
    if (sum_wide >= {1'b0, sfpc_pkg::ChecksumBase}) begin
      sum_d = sfpc_pkg::ByteW'(sum_wide - {1'b0, sfpc_pkg::ChecksumBase});
    end else begin
      sum_d = sum_wide[sfpc_pkg::ByteW-1:0];
    end
  end

  assign count_inc = count_q + 1'b1;
  assign idx_inc   = {1'b0, idx_q} + 1'b1;
  assign limit     = (max_payload_q < sfpc_pkg::LenW'(sfpc_pkg::MaxPayload))
                   ? max_payload_q : sfpc_pkg::LenW'(sfpc_pkg::MaxPayload);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      key_q   <= '0;
      len_q   <= '0;
      count_q <= '0;
      sum_q   <= '0;
      idx_q   <= '0;
      empty_q <= 1'b0;
    end else begin
      if (cmd_i.ld_addr_hi) addr_q[15:8] <= rx_byte_i;
      if (cmd_i.ld_addr_lo) addr_q[7:0]  <= rx_byte_i;
      if (cmd_i.ld_key)     key_q        <= rx_byte_i;
      if (cmd_i.ld_len) begin
        len_q   <= rx_byte_i[sfpc_pkg::LenW-1:0];
        count_q <= '0;
        sum_q   <= '0;
      end
      if (cmd_i.wr_byte) begin
        count_q <= count_inc;
        sum_q   <= sum_d;
      end
      if (cmd_i.start_emit) begin
        idx_q   <= '0;
        empty_q <= (len_q == '0);
      end else if (cmd_i.inc_idx) begin
        idx_q   <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) store_q[count_q[sfpc_pkg::IdxW-1:0]] <= rx_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_byte) rd_q <= store_q[idx_q];
  end

  always_comb begin
    sts_o.sync_first_hit  = (rx_byte_i == sync_first_q);
    sts_o.sync_second_hit = (rx_byte_i == sync_second_q);
    sts_o.key_hit         = (rx_byte_i == key_one_q) || (rx_byte_i == key_two_q)
                         || (rx_byte_i == key_three_q) || (rx_byte_i == key_four_q);
    sts_o.len_zero        = (rx_byte_i == '0);
    sts_o.len_over        = (rx_byte_i > {1'b0, limit});
    sts_o.data_done       = (count_inc >= len_q);
    sts_o.sum_match       = (rx_byte_i == (sfpc_pkg::ChecksumBase - sum_q));
    sts_o.frame_empty     = (len_q == '0);
    sts_o.out_last        = empty_q || (idx_inc == len_q);
  end

  assign sender_address_o = addr_q;
  assign frame_key_o      = key_q;
  assign payload_byte_o   = empty_q ? '0 : rd_q;
  assign byte_index_o     = idx_q;
  assign has_payload_o    = !empty_q;

endmodule

@@ src/sfpc_controller.sv @@
// Controller: frame phase state machine, handshakes and datapath commands.
module sfpc_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  sfpc_pkg::sts_t sts_i,
  output sfpc_pkg::cmd_t cmd_o
);

  localparam logic [3:0] StSync1 = 4'd0;
  localparam logic [3:0] StSync2 = 4'd1;
  localparam logic [3:0] StAddrH = 4'd2;
  localparam logic [3:0] StAddrL = 4'd3;
  localparam logic [3:0] StKey   = 4'd4;
  localparam logic [3:0] StLen   = 4'd5;
  localparam logic [3:0] StData  = 4'd6;
  localparam logic [3:0] StCheck = 4'd7;
  localparam logic [3:0] StRead  = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       in_fire, out_fire;

  assign in_ready_o  = (state_q != StRead) && (state_q != StOut);
  assign out_valid_o = (state_q == StOut);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StSync1: if (in_fire && sts_i.sync_first_hit) state_d = StSync2;
      StSync2: if (in_fire) state_d = sts_i.sync_second_hit ? StAddrH : StSync1;
      StAddrH: if (in_fire) begin
        cmd_o.ld_addr_hi = 1'b1;
        state_d          = StAddrL;
      end
      StAddrL: if (in_fire) begin
        cmd_o.ld_addr_lo = 1'b1;
        state_d          = StKey;
      end
      StKey: if (in_fire) begin
        cmd_o.ld_key = 1'b1;
        state_d      = sts_i.key_hit ? StLen : StSync1;
      end
      StLen: if (in_fire) begin
        if (sts_i.len_over) begin
          state_d = StSync1;
        end else begin
          cmd_o.ld_len = 1'b1;
          state_d      = sts_i.len_zero ? StCheck : StData;
        end
      end
      StData: if (in_fire) begin
        cmd_o.wr_byte = 1'b1;
        if (sts_i.data_done) state_d = StCheck;
      end
      StCheck: if (in_fire) begin
        // drop the frame on a checksum mismatch
        if (sts_i.sum_match) begin
          cmd_o.start_emit = 1'b1;
          state_d          = sts_i.frame_empty ? StOut : StRead;
        end else begin
          state_d = StSync1;
        end
      end
      StRead: begin
        cmd_o.rd_byte = 1'b1;
        state_d       = StOut;
      end
      StOut: if (out_fire) begin
        if (sts_i.out_last) begin
          state_d = StSync1;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d       = StRead;
        end
      end
      default: state_d = StSync1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StSync1;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/sync_frame_parser_checksum_unit.sv @@
// Top level: sync-framed TLV parser with mod-255 checksum, stream in and out.
// Input: one received byte per cycle while hunting, reading the header and payload.
// Output: a verified frame begins with a store read after its checksum byte (none if empty);
// each payload result then takes a payload store read and the output register.
// Input is held off while a frame's results are being sent.
// Reset (async, active low) returns to sync hunt with registers at their defaults.
module sync_frame_parser_checksum_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // rx_data
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // sender_address[15:0], frame_key[23:16], payload_byte[31:24], byte_index[37:32], zero pad
  output logic [sfpc_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tuser,  // has_payload
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sfpc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [sfpc_pkg::ByteW-1:0]          cfg_data_i
);

  `include "sync_frame_parser_checksum_unit_assert.svh"

  sfpc_pkg::cmd_t             cmd;
  sfpc_pkg::sts_t             sts;
  logic [15:0]                sender_address;
  logic [sfpc_pkg::ByteW-1:0] frame_key;
  logic [sfpc_pkg::ByteW-1:0] payload_byte;
  logic [sfpc_pkg::IdxW-1:0]  byte_index;
  logic                       has_payload;

  assign cfg_ready_o = 1'b1;

  sfpc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sfpc_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .rx_byte_i        (s_axis_tdata),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sender_address_o (sender_address),
    .frame_key_o      (frame_key),
    .payload_byte_o   (payload_byte),
    .byte_index_o     (byte_index),
    .has_payload_o    (has_payload)
  );

  assign m_axis_tdata = {2'b00, byte_index, payload_byte, frame_key, sender_address};
  assign m_axis_tlast = sts.out_last;
  assign m_axis_tuser = has_payload;

  `SFPC_ASSERT_ALWAYS(a_no_in_during_out, !(s_axis_tready && m_axis_tvalid),
    "input ready while a result is pending")
  `SFPC_ASSERT_SAME(a_empty_is_last, m_axis_tvalid && !m_axis_tuser, m_axis_tlast,
    "empty-frame result not marked last")
  `SFPC_ASSERT_NEXT(a_resume_hunt, m_axis_tvalid && m_axis_tready && m_axis_tlast,
    s_axis_tready && !m_axis_tvalid, "no return to sync hunt after last result")
  `SFPC_ASSERT_SAME(a_empty_fields, m_axis_tvalid && !m_axis_tuser,
    m_axis_tdata[37:24] == 14'd0, "empty-frame result carries payload fields")

endmodule
